FILE: src/hmtm_pkg.sv
`default_nettype none

package hmtm_pkg;

   // table geometry
   localparam int NAME_COUNT   = 27;
   localparam int NAME_MAX_LEN = 11;
   localparam int POS_W        = 4;
   localparam int CODE_W       = 5;
   localparam int LEN_W        = 4;

   localparam logic [POS_W-1:0]      POS_MAX  = 4'd15;
   localparam logic [NAME_COUNT-1:0] ALL_LIVE = {NAME_COUNT{1'b1}};

   // ascii letter bounds and the case offset
   localparam logic [7:0] LOWER_A    = 8'h61;
   localparam logic [7:0] LOWER_Z    = 8'h7a;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   // method names, left-justified, zero-padded to the longest name
   localparam logic [8*NAME_MAX_LEN-1:0] NAME_TEXT [NAME_COUNT] = '{
      {"DELETE",      40'h0},
      {"GET",         64'h0},
      {"HEAD",        56'h0},
      {"POST",        56'h0},
      {"PUT",         64'h0},
      {"CONNECT",     32'h0},
      {"OPTIONS",     32'h0},
      {"TRACE",       48'h0},
      {"COPY",        56'h0},
      {"LOCK",        56'h0},
      {"MKCOL",       48'h0},
      {"MOVE",        56'h0},
      {"PROPFIND",    24'h0},
      {"PROPPATCH",   16'h0},
      {"SEARCH",      40'h0},
      {"UNLOCK",      40'h0},
      {"REPORT",      40'h0},
      {"MKACTIVITY",   8'h0},
      {"CHECKOUT",    24'h0},
      {"MERGE",       48'h0},
      {"M-SEARCH",    24'h0},
      {"NOTIFY",      40'h0},
      {"SUBSCRIBE",   16'h0},
      {"UNSUBSCRIBE"},
      {"PATCH",       48'h0},
      {"PURGE",       48'h0},
      {"MKCALENDAR",   8'h0}
   };

   localparam logic [LEN_W-1:0] NAME_LEN [NAME_COUNT] = '{
      4'd6, 4'd3, 4'd4, 4'd4, 4'd3, 4'd7, 4'd7, 4'd5, 4'd4, 4'd4, 4'd5, 4'd4,
      4'd8, 4'd9, 4'd6, 4'd6, 4'd6, 4'd10, 4'd8, 4'd5, 4'd8, 4'd6, 4'd9,
      4'd11, 4'd5, 4'd5, 4'd10
   };

   // compare outcome handed from the matcher core to the top level
   typedef struct packed {
      logic [NAME_COUNT-1:0] next_mask;
      logic                  matched;
      logic [CODE_W-1:0]     code;
   } cmp_result_type;

endpackage

`default_nettype wire

FILE: src/hmtm_compare.sv
`default_nettype none

module hmtm_compare (
   input  wire logic [hmtm_pkg::NAME_COUNT-1:0] live_mask,
   input  wire logic [hmtm_pkg::POS_W-1:0]      position,
   input  wire logic [7:0]                      token_byte,
   output hmtm_pkg::cmp_result_type             result
);
   import hmtm_pkg::*;

   logic [7:0]            folded;
   logic [NAME_COUNT-1:0] next_mask;
   logic [NAME_COUNT-1:0] full_hit;
   logic [LEN_W:0]        seen_len;

   // fold a..z to upper case
   always_comb begin
      if (token_byte >= LOWER_A && token_byte <= LOWER_Z) begin
         folded = token_byte - CASE_SHIFT;
      end else begin
         folded = token_byte;
      end
   end

   // parallel compare of every live name at the current position
   always_comb begin
      next_mask = '0;
      for (int i = 0; i < NAME_COUNT; i++) begin
         for (int p = 0; p < NAME_MAX_LEN; p++) begin
            if (live_mask[i] && position == POS_W'(p) && POS_W'(p) < NAME_LEN[i] &&
                NAME_TEXT[i][8*(NAME_MAX_LEN-p)-1 -: 8] == folded) begin
               next_mask[i] = 1'b1;
            end
         end
      end
   end

   // names that end exactly on this byte
   assign seen_len = {1'b0, position} + (LEN_W+1)'(1);

   always_comb begin
      for (int i = 0; i < NAME_COUNT; i++) begin
         full_hit[i] = next_mask[i] && ({1'b0, NAME_LEN[i]} == seen_len);
      end
   end

   // names are distinct, so at most one full hit: or-encode its index
   always_comb begin
      result.next_mask = next_mask;
      result.matched   = |full_hit;
      result.code      = '0;
      for (int i = 0; i < NAME_COUNT; i++) begin
         if (full_hit[i]) begin
            result.code = result.code | CODE_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

FILE: src/http_method_token_matcher.sv
`default_nettype none

// channel  | dir | signals                      | contents
// ---------+-----+------------------------------+----------------------------------
// req      | in  | tvalid tready tdata[7:0]     | token_byte; tlast = final_byte
// rsp      | out | tvalid tready tdata[7:0]     | method_code [4:0], zero [7:5];
//          |     | tuser[0]                     | tuser = matched
//
// one word per cycle sustained unless a final byte waits on a stalled result; a result
// passes the input register, then the result register around one compare stage
// the compare stage checks all 27 names in parallel against the held byte
// reset clears the live mask to all names, the position to zero, both valids
// a stalled result holds only a final byte in the input register; other bytes
// keep flowing since they produce no result

module http_method_token_matcher (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] token_byte
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [4:0] method_code, [7:5] zero
   output logic [0:0]      rsp_tuser    // [0] matched
);
   import hmtm_pkg::*;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff, in_byte_in;
   logic                  in_last_ff, in_last_in;

   // token state
   logic [NAME_COUNT-1:0] mask_ff, mask_in;
   logic [POS_W-1:0]      pos_ff, pos_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic                  out_matched_ff, out_matched_in;
   logic [CODE_W-1:0]     out_code_ff, out_code_in;

   logic                  out_free;
   logic                  proceed;
   logic                  req_take;
   cmp_result_type        cmp;

   hmtm_compare u_compare (
      .live_mask  (mask_ff),
      .position   (pos_ff),
      .token_byte (in_byte_ff),
      .result     (cmp)
   );

   // handshake control
   assign out_free   = !out_valid_ff || rsp_tready;
   assign proceed    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || proceed;
   assign req_take   = req_tvalid && req_tready;

   // input register next values
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end else if (proceed) begin
         in_valid_in = 1'b0;
      end
   end

   // token state next values
   always_comb begin
      mask_in = mask_ff;
      pos_in  = pos_ff;
      if (proceed) begin
         if (in_last_ff) begin
            mask_in = ALL_LIVE;
            pos_in  = '0;
         end else begin
            mask_in = cmp.next_mask;
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   // result register next values
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_matched_in = out_matched_ff;
      out_code_in    = out_code_ff;
      if (proceed && in_last_ff) begin
         out_valid_in   = 1'b1;
         out_matched_in = cmp.matched;
         out_code_in    = cmp.code;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mask_ff      <= ALL_LIVE;
         pos_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mask_ff      <= mask_in;
         pos_ff       <= pos_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff     <= in_byte_in;
      in_last_ff     <= in_last_in;
      out_matched_ff <= out_matched_in;
      out_code_ff    <= out_code_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_code_ff};
   assign rsp_tuser  = out_matched_ff;

`ifndef NO_ASSERTIONS
   // the state returns to its start after a final byte
   a_token_restart : assert property (@(posedge clock) disable iff (reset)
      proceed && in_last_ff |=> pos_ff == '0 && mask_ff == ALL_LIVE)
      else $error("token state not restarted after final byte");

   // past the longest name nothing can still be live
   a_long_dead : assert property (@(posedge clock) disable iff (reset)
      pos_ff > POS_W'(NAME_MAX_LEN) |-> mask_ff == '0)
      else $error("live name beyond longest name length");

   // a failed token reports code zero, a match reports a table index
   a_code_range : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_matched_ff ? (out_code_ff < CODE_W'(NAME_COUNT))
                                       : (out_code_ff == '0)))
      else $error("method code out of range");

   // a held input word is not overwritten
   a_input_hold : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proceed |=> in_valid_ff && $stable(in_byte_ff)
                                  && $stable(in_last_ff))
      else $error("held input word lost");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/method_checker.sv
module method_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] token_byte
   input  wire logic       req_tlast,
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,   // [4:0] method_code, [7:5] zero
   input  wire logic [0:0] rsp_tuser,   // [0] matched
   output int              fail_count,
   output int              pending_count
);

   localparam int         VERB_COUNT = 27;
   localparam logic [3:0] POS_LIMIT  = 4'd15;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   typedef struct packed {
      logic       matched;
      logic [4:0] code;
   } method_verdict_type;

   // known methods in code order
   string verb_names [VERB_COUNT] = '{
      "DELETE", "GET", "HEAD", "POST", "PUT", "CONNECT", "OPTIONS", "TRACE",
      "COPY", "LOCK", "MKCOL", "MOVE", "PROPFIND", "PROPPATCH", "SEARCH",
      "UNLOCK", "REPORT", "MKACTIVITY", "CHECKOUT", "MERGE", "M-SEARCH",
      "NOTIFY", "SUBSCRIBE", "UNSUBSCRIBE", "PATCH", "PURGE", "MKCALENDAR"
   };

   logic [VERB_COUNT-1:0] live_verbs;
   logic [3:0]            next_pos;
   method_verdict_type    verdict_q [$];
   int                    errors = 0;

   assign fail_count = errors;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   function automatic logic [7:0] upper_case(input logic [7:0] b);
      if (b >= "a" && b <= "z") begin
         return b - CASE_BIT;
      end
      return b;
   endfunction

   // narrow the live set by one token word; close the token on its last word
   task automatic predict_word(input logic [7:0] raw, input logic last);
      logic [7:0]            b;
      logic [VERB_COUNT-1:0] still_live;
      method_verdict_type    v;
      b = upper_case(raw);
      still_live = '0;
      for (int n = 0; n < VERB_COUNT; n++) begin
         if (live_verbs[n] && int'(next_pos) < verb_names[n].len()) begin
            if (verb_names[n][int'(next_pos)] == b) begin
               still_live[n] = 1'b1;
            end
         end
      end
      if (!last) begin
         live_verbs = still_live;
         if (next_pos != POS_LIMIT) begin
            next_pos = next_pos + 4'd1;
         end
      end else begin
         // lowest-coded full-length survivor wins
         v = '0;
         for (int n = VERB_COUNT - 1; n >= 0; n--) begin
            if (still_live[n] && verb_names[n].len() == int'(next_pos) + 1) begin
               v.matched = 1'b1;
               v.code    = n[4:0];
            end
         end
         verdict_q.push_back(v);
         live_verbs = '1;
         next_pos   = '0;
      end
   endtask

   // compare one result word with the oldest prediction
   task automatic check_verdict();
      method_verdict_type v;
      if (verdict_q.size() == 0) begin
         report_mismatch($sformatf("result word with nothing expected (code %0d)",
                                   rsp_tdata[4:0]));
      end else begin
         v = verdict_q.pop_front();
         if (rsp_tuser[0] !== v.matched) begin
            report_mismatch($sformatf("matched got %0b, expected %0b",
                                      rsp_tuser[0], v.matched));
         end
         if (rsp_tdata[4:0] !== v.code) begin
            report_mismatch($sformatf("method_code got %0d, expected %0d",
                                      rsp_tdata[4:0], v.code));
         end
         if (rsp_tdata[7:5] !== 3'b000) begin
            report_mismatch($sformatf("padding bits got %0b, expected 000",
                                      rsp_tdata[7:5]));
         end
      end
   endtask

   // watch both channels at every edge
   always @(posedge clock) begin
      if (reset) begin
         live_verbs = '1;
         next_pos   = '0;
         verdict_q.delete();
         pending_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_verdict();
         end
         if (req_tvalid && req_tready) begin
            predict_word(req_tdata, req_tlast);
         end
         pending_count <= verdict_q.size();
      end
   end

endmodule

FILE: tb/sv/testbench.sv
module testbench;

   import hmtm_pkg::*;

   localparam int         RANDOM_WORDS = 1750;
   localparam int         STALL_LIMIT  = 3000;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         BURST_TOKENS = 40;
   localparam logic [7:0] CASE_BIT     = 8'h20;
   localparam logic [7:0] HIGH_BIT     = 8'h80;

   typedef enum logic [1:0] {
      MODE_RECV_SLOW,
      MODE_SEND_SLOW,
      MODE_NO_IDLE
   } idle_mode_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] token_byte
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [4:0] method_code, [7:5] zero
   logic [0:0] rsp_tuser;   // [0] matched

   int            fail_count;
   int            pending_count;
   idle_mode_type idle_mode;
   logic          hold_trigger;
   logic [7:0]    token_bytes [$];
   int            words_sent;
   int            stall_cycles;

   http_method_token_matcher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   method_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int send_gap_pct(input idle_mode_type m);
      case (m)
         MODE_RECV_SLOW: return 6;
         MODE_SEND_SLOW: return 68;
         default:        return 0;
      endcase
   endfunction

   function automatic int recv_gap_pct(input idle_mode_type m);
      case (m)
         MODE_RECV_SLOW: return 68;
         MODE_SEND_SLOW: return 6;
         default:        return 0;
      endcase
   endfunction

   // receiver: random back-pressure, plus one long hold-off when asked
   initial begin : receiver
      int  hold_left;
      bit  hold_done;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_trigger && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_gap_pct(idle_mode));
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // offer one word, with a random gap ahead of it
   task automatic send_word(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_gap_pct(idle_mode)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic send_token();
      for (int k = 0; k < token_bytes.size(); k++) begin
         send_word(token_bytes[k], k == token_bytes.size() - 1);
      end
      token_bytes.delete();
   endtask

   task automatic push_text(input string s);
      for (int k = 0; k < s.len(); k++) begin
         token_bytes.push_back(s[k]);
      end
   endtask

   // a known method with each letter in random case
   task automatic push_name(input int idx);
      logic [7:0] c;
      for (int k = 0; k < int'(NAME_LEN[idx]); k++) begin
         c = NAME_TEXT[idx][8*NAME_MAX_LEN-1-8*k -: 8];
         if (c >= "A" && c <= "Z" && $urandom_range(1)) begin
            c = c | CASE_BIT;
         end
         token_bytes.push_back(c);
      end
   endtask

   // near-miss variants of a byte
   function automatic logic [7:0] twist_byte(input logic [7:0] b);
      case ($urandom_range(3))
         0:       return 8'($urandom_range(255));
         1:       return b ^ CASE_BIT;
         2:       return b ^ HIGH_BIT;
         default: return b + 8'd1;
      endcase
   endfunction

   // mostly well-formed names, the rest broken names and noise
   task automatic build_random_token();
      int kind;
      int idx;
      int len;
      int pos;
      kind = $urandom_range(99);
      idx  = $urandom_range(NAME_COUNT - 1);
      if (kind < 60) begin
         push_name(idx);
      end else if (kind < 70) begin
         push_name(idx);
         pos = $urandom_range(token_bytes.size() - 1);
         token_bytes[pos] = twist_byte(token_bytes[pos]);
      end else if (kind < 78) begin
         push_name(idx);
         len = $urandom_range(1, token_bytes.size() - 1);
         while (token_bytes.size() > len) void'(token_bytes.pop_back());
      end else if (kind < 86) begin
         push_name(idx);
         len = $urandom_range(1, 6);
         repeat (len) token_bytes.push_back(8'($urandom_range(255)));
      end else begin
         len = $urandom_range(1, 18);
         repeat (len) token_bytes.push_back(8'($urandom_range(255)));
      end
   endtask

   // stimulus
   initial begin : stimulus
      int start;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      hold_trigger = 1'b0;
      idle_mode    = MODE_RECV_SLOW;
      words_sent   = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: lowest and highest codes, longest name, case folding
      push_text("DELETE");       send_token();
      push_text("mkcalendar");   send_token();
      push_text("UnSubscribe");  send_token();
      // hyphen matches only itself, never its case-flipped form
      push_text("m-search");     send_token();
      push_text("M");
      token_bytes.push_back("-" ^ CASE_BIT);
      push_text("SEARCH");       send_token();
      // prefix and overrun of a name
      push_text("ge");           send_token();
      push_text("GETS");         send_token();
      // zero byte and all-ones byte, alone and inside a name
      token_bytes.push_back(8'h00); send_token();
      token_bytes.push_back(8'hff); send_token();
      push_text("GET");
      token_bytes.push_back(8'h00); send_token();
      // top bit set is not folded
      token_bytes.push_back("P" | HIGH_BIT);
      push_text("UT");           send_token();
      // bytes just outside the letter ranges
      push_text("`ET");          send_token();
      push_text("{ET");          send_token();
      // long token saturates the position
      push_text("PROPPATCHPROPPATCH"); send_token();

      // random phase, idling pattern changes by thirds
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         if (words_sent - start >= 2 * RANDOM_WORDS / 3 && idle_mode != MODE_NO_IDLE) begin
            idle_mode    <= MODE_NO_IDLE;
            hold_trigger <= 1'b1;
            // single-word tokens so the block fills up during the hold-off
            repeat (BURST_TOKENS) begin
               token_bytes.push_back(8'($urandom_range(255)));
               send_token();
            end
         end else if (words_sent - start >= RANDOM_WORDS / 3 &&
                      idle_mode == MODE_RECV_SLOW) begin
            idle_mode <= MODE_SEND_SLOW;
         end
         build_random_token();
         send_token();
      end
      req_tvalid <= 1'b0;

      // drain and settle
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
